// File: design/sipq_pkg.sv
// shared constants and types for the sorted insert priority queue
package sipq_pkg;

  localparam int DEPTH = 8;
  localparam int JOB_W = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 4;
  localparam int STATUS_W = 2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic insert_en;
    logic remove_en;
    logic occupied;
    logic at_tail;
  } cell_ctrl_t;

endpackage

// File: design/sipq_cell.sv
// one compare-and-shift slot of the sorted queue
module sipq_cell (
  input  logic                                clk,
  input  sipq_pkg::cell_ctrl_t                ctrl,
  input  logic signed [sipq_pkg::JOB_W-1:0]   job,
  input  logic signed [sipq_pkg::JOB_W-1:0]   left_entry,
  input  logic                                left_gt,
  input  logic signed [sipq_pkg::JOB_W-1:0]   right_entry,
  output logic signed [sipq_pkg::JOB_W-1:0]   entry,
  output logic                                gt
);

  logic take;

  // slot holds a job larger than the new one, so it moves up
  assign gt   = ctrl.occupied && (entry > job);
  assign take = gt || ctrl.at_tail;

  always_ff @(posedge clk) begin
    if (ctrl.insert_en && take) begin
      entry <= left_gt ? left_entry : job;
    end else if (ctrl.remove_en) begin
      entry <= right_entry;
    end
  end

endmodule

// File: design/sorted_insert_priority_queue.sv
// top level: bounded sorted priority queue built from a row of shift cells
//
//  channel  dir  tdata                                   tuser
//  s_*      in   job_value[15:0]                         action[0]
//  m_*      out  removed_job[15:0] occupancy[19:16]      status[1:0]
//
// one item per cycle: every cell compares against the new job and shifts in
// the same cycle, and the result sits in an output register.
// a new item is taken while the held result is taken or the register is empty.
// rst clears the count and the output valid; slot contents need no reset.
// a stalled result holds the input side until it leaves.
module sorted_insert_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // job_value[15:0]
  input  logic [0:0]  s_tuser,   // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // removed_job[15:0], occupancy[19:16], zero pad
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int D = sipq_pkg::DEPTH;
  localparam int JW = sipq_pkg::JOB_W;
  localparam int CW = sipq_pkg::CNT_W;

  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic signed [JW-1:0]      job;
  logic signed [JW-1:0]      entries [D];
  logic                      gts [D];
  logic                      accept;
  logic                      full;
  logic                      empty;
  logic                      insert_en;
  logic                      remove_en;
  sipq_pkg::status_t         status;
  sipq_pkg::status_t         status_next;
  logic signed [JW-1:0]      removed_job;
  logic signed [JW-1:0]      removed_next;
  logic [sipq_pkg::OCC_W-1:0] occupancy;

  assign job       = s_tdata;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign full      = (count == CW'(D));
  assign empty     = (count == '0);
  assign insert_en = accept && (s_tuser[0] == sipq_pkg::ACT_INSERT) && !full;
  assign remove_en = accept && (s_tuser[0] == sipq_pkg::ACT_REMOVE) && !empty;

  genvar i;
  generate
    for (i = 0; i < D; i++) begin : g_cell
      sipq_pkg::cell_ctrl_t ctrl;
      logic signed [JW-1:0] left_entry;
      logic                 left_gt;
      logic signed [JW-1:0] right_entry;

      // fields: insert_en, remove_en, occupied, at_tail
      assign ctrl = {insert_en, remove_en, (CW'(i) < count), (CW'(i) == count)};

      if (i == 0) begin : g_head
        assign left_entry = job;
        assign left_gt    = 1'b0;
      end else begin : g_body
        assign left_entry = entries[i-1];
        assign left_gt    = gts[i-1];
      end

      if (i == D - 1) begin : g_last
        assign right_entry = entries[i];
      end else begin : g_inner
        assign right_entry = entries[i+1];
      end

      sipq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .job         (job),
        .left_entry  (left_entry),
        .left_gt     (left_gt),
        .right_entry (right_entry),
        .entry       (entries[i]),
        .gt          (gts[i])
      );
    end
  endgenerate

  always_comb begin
    count_next   = count;
    status_next  = sipq_pkg::ST_DONE;
    removed_next = '0;
    if (s_tuser[0] == sipq_pkg::ACT_INSERT) begin
      if (full) begin
        status_next = sipq_pkg::ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (empty) begin
        status_next = sipq_pkg::ST_EMPTY;
      end else begin
        removed_next = entries[0];
        count_next   = count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      removed_job <= removed_next;
      occupancy   <= sipq_pkg::OCC_W'(count_next);
    end
  end

  assign m_tdata = {4'b0, occupancy, removed_job};
  assign m_tuser = status;

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the sorted insert priority queue
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sipq_pkg::status_t  status;
    logic signed [15:0] removed_job;
    logic        [3:0]  occupancy;
  } queue_result_t;

  typedef struct packed {
    logic               act;
    logic signed [15:0] job;
    logic               typed;
    sipq_pkg::status_t  status;
    logic signed [15:0] removed_job;
    logic        [3:0]  occupancy;
  } plan_row_t;

  localparam int RANDOM_ITEMS = 650;
  localparam int PLAN_ROWS = 21;

  // directed rows, typed results only where the order is obvious
  localparam plan_row_t PLAN[PLAN_ROWS] = '{
    '{sipq_pkg::ACT_REMOVE, 16'sh0000, 1'b1, sipq_pkg::ST_EMPTY, 16'sh0000, 4'd0},
    '{sipq_pkg::ACT_INSERT, 16'sh7FFF, 1'b1, sipq_pkg::ST_DONE,  16'sh0000, 4'd1},
    '{sipq_pkg::ACT_INSERT, 16'sh8000, 1'b1, sipq_pkg::ST_DONE,  16'sh0000, 4'd2},
    '{sipq_pkg::ACT_INSERT, 16'sh0000, 1'b1, sipq_pkg::ST_DONE,  16'sh0000, 4'd3},
    '{sipq_pkg::ACT_INSERT, 16'sh0005, 1'b0, sipq_pkg::ST_DONE,  16'sh0000, 4'd0},
    '{sipq_pkg::ACT_INSERT, 16'sh0005, 1'b0, sipq_pkg::ST_DONE,  16'sh0000, 4'd0},
    '{sipq_pkg::ACT_INSERT, 16'shFFFF, 1'b0, sipq_pkg::ST_DONE,  16'sh0000, 4'd0},
    '{sipq_pkg::ACT_INSERT, 16'sh5555, 1'b0, sipq_pkg::ST_DONE,  16'sh0000, 4'd0},
    '{sipq_pkg::ACT_INSERT, 16'shAAAA, 1'b1, sipq_pkg::ST_DONE,  16'sh0000, 4'd8},
    '{sipq_pkg::ACT_INSERT, 16'sh0064, 1'b1, sipq_pkg::ST_FULL,  16'sh0000, 4'd8},
    '{sipq_pkg::ACT_REMOVE, 16'shFFFF, 1'b1, sipq_pkg::ST_DONE,  16'sh8000, 4'd7},
    '{sipq_pkg::ACT_REMOVE, 16'sh0000, 1'b1, sipq_pkg::ST_DONE,  16'shAAAA, 4'd6},
    '{sipq_pkg::ACT_REMOVE, 16'sh1234, 1'b0, sipq_pkg::ST_DONE,  16'sh0000, 4'd0},
    '{sipq_pkg::ACT_REMOVE, 16'sh0000, 1'b0, sipq_pkg::ST_DONE,  16'sh0000, 4'd0},
    '{sipq_pkg::ACT_REMOVE, 16'sh0000, 1'b0, sipq_pkg::ST_DONE,  16'sh0000, 4'd0},
    '{sipq_pkg::ACT_REMOVE, 16'sh0000, 1'b0, sipq_pkg::ST_DONE,  16'sh0000, 4'd0},
    '{sipq_pkg::ACT_REMOVE, 16'sh0000, 1'b0, sipq_pkg::ST_DONE,  16'sh0000, 4'd0},
    '{sipq_pkg::ACT_REMOVE, 16'sh0000, 1'b0, sipq_pkg::ST_DONE,  16'sh0000, 4'd0},
    '{sipq_pkg::ACT_REMOVE, 16'sh7FFF, 1'b1, sipq_pkg::ST_EMPTY, 16'sh0000, 4'd0},
    '{sipq_pkg::ACT_INSERT, 16'sh8000, 1'b1, sipq_pkg::ST_DONE,  16'sh0000, 4'd1},
    '{sipq_pkg::ACT_REMOVE, 16'sh0000, 1'b1, sipq_pkg::ST_DONE,  16'sh8000, 4'd0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // job_value[15:0]
  logic [0:0]  s_tuser;   // action[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // removed_job[15:0], occupancy[19:16], zero pad
  logic [1:0]  m_tuser;   // status[1:0]

  logic signed [15:0] ref_slots[sipq_pkg::DEPTH];
  int                 ref_count;
  queue_result_t      pending_results[$];
  int                 error_count;
  int                 burst_left;

  sorted_insert_priority_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // runs one job through the queue model and returns what the block should report
  function automatic queue_result_t apply_job(logic act, logic signed [15:0] job);
    queue_result_t res;
    int pos;
    res = '{sipq_pkg::ST_DONE, 16'sh0000, 4'd0};
    if (act == sipq_pkg::ACT_INSERT) begin
      if (ref_count >= sipq_pkg::DEPTH) begin
        res.status = sipq_pkg::ST_FULL;
      end else begin
        pos = ref_count;
        while (pos > 0 && ref_slots[pos-1] > job) begin
          ref_slots[pos] = ref_slots[pos-1];
          pos--;
        end
        ref_slots[pos] = job;
        ref_count++;
      end
    end else begin
      if (ref_count == 0) begin
        res.status = sipq_pkg::ST_EMPTY;
      end else begin
        res.removed_job = ref_slots[0];
        for (int i = 1; i < ref_count; i++) ref_slots[i-1] = ref_slots[i];
        ref_count--;
      end
    end
    res.occupancy = ref_count[3:0];
    return res;
  endfunction

  task automatic hold_idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);
      s_tuser  <= 1'($urandom);
    end
  endtask

  // offers one item, waits for the handshake, then records its expected result
  task automatic send_job(logic act, logic signed [15:0] job, logic typed,
                          queue_result_t typed_res);
    queue_result_t res;
    if (burst_left == 0) begin
      hold_idle($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= job;
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    res = apply_job(act, job);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  function automatic logic signed [15:0] pick_job();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'($signed($urandom_range(0, 8)) - 4);  // near-equal values
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int insert_pct;
    logic act;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    error_count = 0;
    ref_count = 0;
    burst_left = 0;
    insert_pct = 50;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++)
      send_job(PLAN[r].act, PLAN[r].job, PLAN[r].typed,
               '{PLAN[r].status, PLAN[r].removed_job, PLAN[r].occupancy});

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // swing the insert bias so the queue keeps running full and empty
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      act = ($urandom_range(0, 99) < insert_pct) ? sipq_pkg::ACT_INSERT
                                                 : sipq_pkg::ACT_REMOVE;
      send_job(act, pick_job(), 1'b0, '0);
    end

    hold_idle(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // receiver stall pattern: always ready, a rotating random mask, or mostly stalled
  initial begin
    int mode;
    int mode_left;
    logic [7:0] mask;
    m_tready = 1'b0;
    mode = 0;
    mode_left = 0;
    mask = 8'hFF;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 100);
        mask = 8'($urandom);
      end
      mode_left--;
      mask = {mask[6:0], mask[7]};
      case (mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= mask[0];
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: status %0d removed_job %0d",
               m_tuser, $signed(m_tdata[15:0]));
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          error_count++;
        end
        if (m_tdata[15:0] !== want.removed_job) begin
          $error("removed_job: expected %0d, got %0d", want.removed_job,
                 $signed(m_tdata[15:0]));
          error_count++;
        end
        if (m_tdata[19:16] !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, m_tdata[19:16]);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
